### rtl/kbt_pkg.sv
`default_nettype none
// kbt_pkg: shared constants and types for the keltner breakout trader
// no dependencies

package kbt_pkg;

  localparam int PriceW       = 28;
  localparam int AccW         = 40;
  localparam int PnlW         = 24;
  localparam int HistDepthDef = 512;
  localparam int AtrSeedDef   = 14;
  localparam int CntW         = 10;
  localparam int CntMax       = 1023;
  localparam int DivNumW      = 64;
  localparam int DivDenW      = 44;

  localparam logic [15:0] EMA_COEFF_RST  = 16'd6242;
  localparam logic [8:0]  LOOKBACK_RST   = 9'd200;
  localparam logic [11:0] BAND_MULT_RST  = 12'd512;
  localparam logic [11:0] STOP_MULT_RST  = 12'd640;
  localparam logic [15:0] HALF_SPRD_RST  = 16'd0;
  localparam logic [11:0] FEE_SCALE_RST  = 12'd256;

  localparam logic [2:0] REG_EMA_COEFF = 3'd0;
  localparam logic [2:0] REG_LOOKBACK  = 3'd1;
  localparam logic [2:0] REG_BAND_MULT = 3'd2;
  localparam logic [2:0] REG_STOP_MULT = 3'd3;
  localparam logic [2:0] REG_HALF_SPRD = 3'd4;
  localparam logic [2:0] REG_FEE_SCALE = 3'd5;

  localparam logic [1:0] EXIT_NONE = 2'd0;
  localparam logic [1:0] EXIT_STOP = 2'd1;
  localparam logic [1:0] EXIT_EMA  = 2'd2;

  typedef struct packed {
    logic [15:0] ema_coeff;
    logic [8:0]  trend_lookback;
    logic [11:0] band_mult;
    logic [11:0] stop_mult;
    logic [15:0] half_spread;
    logic [11:0] fee_scale;
  } kbt_cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture bar, read history
    logic calc;       // ema / tr / atr numerator
    logic atr_start;  // start atr division
    logic decide;     // entry/exit decision
    logic pnl_start;  // start pnl division
    logic finish;     // write back, build result
  } kbt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_done;
    logic need_pnl;
  } kbt_sts_t;

endpackage

`default_nettype wire

### rtl/keltner_breakout_trend_trader.sv
`default_nettype none
// keltner_breakout_trend_trader: top level, apb register file, ctrl and datapath
// depends on kbt_pkg, kbt_ctrl, kbt_dp
//
// channel  dir   width  contents
// in       in    88     bar_high, bar_low, bar_close
// out      out   88     entered, trade_closed, exit_kind, pnl_bps, in_position, atr_now, ema_now
// cfg      apb   32     six registers at 4*i
//
// a result is valid after the load, calc, atr wait, decide, pnl wait and finish states;
// the first 64-step pass of the shared divider updates the atr, the second one (exits only)
// gives the pnl; a result waits in place until taken and no new bar is accepted meanwhile;
// synchronous reset clears all control state

module keltner_breakout_trend_trader
  import kbt_pkg::*;
#(
  parameter int HISTORY_DEPTH = HistDepthDef,
  parameter int ATR_SEED_BARS = AtrSeedDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [87:0] in_tdata,   // bar_high, bar_low, bar_close
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [87:0]      out_tdata,  // entered, trade_closed, exit_kind, pnl_bps, in_position, atr_now, ema_now
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  kbt_cfg_t cfg_r;
  kbt_cmd_t cmd;
  kbt_sts_t sts;
  logic [84:0] res;
  logic [2:0]  ridx;

  assign cfg_pready = 1'b1;
  assign ridx       = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ema_coeff      <= EMA_COEFF_RST;
      cfg_r.trend_lookback <= LOOKBACK_RST;
      cfg_r.band_mult      <= BAND_MULT_RST;
      cfg_r.stop_mult      <= STOP_MULT_RST;
      cfg_r.half_spread    <= HALF_SPRD_RST;
      cfg_r.fee_scale      <= FEE_SCALE_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (ridx)
        REG_EMA_COEFF: cfg_r.ema_coeff      <= cfg_pwdata[15:0];
        REG_LOOKBACK:  cfg_r.trend_lookback <= cfg_pwdata[8:0];
        REG_BAND_MULT: cfg_r.band_mult      <= cfg_pwdata[11:0];
        REG_STOP_MULT: cfg_r.stop_mult      <= cfg_pwdata[11:0];
        REG_HALF_SPRD: cfg_r.half_spread    <= cfg_pwdata[15:0];
        REG_FEE_SCALE: cfg_r.fee_scale      <= cfg_pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_EMA_COEFF: cfg_prdata = 32'(cfg_r.ema_coeff);
      REG_LOOKBACK:  cfg_prdata = 32'(cfg_r.trend_lookback);
      REG_BAND_MULT: cfg_prdata = 32'(cfg_r.band_mult);
      REG_STOP_MULT: cfg_prdata = 32'(cfg_r.stop_mult);
      REG_HALF_SPRD: cfg_prdata = 32'(cfg_r.half_spread);
      REG_FEE_SCALE: cfg_prdata = 32'(cfg_r.fee_scale);
      default:       cfg_prdata = '0;
    endcase
  end

  kbt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  kbt_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .ATR_SEED_BARS (ATR_SEED_BARS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd       (cmd),
    .sts       (sts),
    .bar_high  (in_tdata[27:0]),
    .bar_low   (in_tdata[55:28]),
    .bar_close (in_tdata[83:56]),
    .res       (res)
  );

  assign out_tdata = {3'b0, res};

endmodule

`default_nettype wire

### rtl/kbt_div.sv
`default_nettype none
// kbt_div: restoring radix-2 divider, unsigned magnitude with sign fix-up
// depends on kbt_pkg

module kbt_div
  import kbt_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [DivNumW-1:0] num,
  input  wire logic [DivDenW-1:0] den,
  input  wire logic               neg,
  output logic      [DivNumW-1:0] quo,
  output logic                    done
);

  localparam int StepW = $clog2(DivNumW + 1);

  logic [DivNumW-1:0] q_r, q_nxt;
  logic [DivDenW:0]   rem_r, rem_nxt;
  logic [DivDenW-1:0] den_r;
  logic               neg_r;
  logic [StepW-1:0]   cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [DivDenW:0]   trial;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[DivDenW-1:0], q_r[DivNumW-1]};
    if (start) begin
      q_nxt    = num;
      rem_nxt  = '0;
      cnt_nxt  = StepW'(DivNumW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt   = {q_r[DivNumW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[DivNumW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == StepW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      den_r <= den;
      neg_r <= neg;
    end
  end

  assign quo  = neg_r ? (~q_r + 1'b1) : q_r;
  assign done = done_r;

endmodule

`default_nettype wire

### rtl/kbt_ctrl.sv
`default_nettype none
// kbt_ctrl: sequencer for one bar, handshakes and command strobes
// depends on kbt_pkg

module kbt_ctrl
  import kbt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  wire logic     out_tready,
  output kbt_cmd_t      cmd,
  input  wire kbt_sts_t sts
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CALC = 3'd1;
  localparam logic [2:0] S_ATRW = 3'd2;
  localparam logic [2:0] S_DEC  = 3'd3;
  localparam logic [2:0] S_PNLW = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;
  localparam logic [2:0] S_LOAD = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       acc;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign acc        = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.load = acc;
        if (acc) state_nxt = S_LOAD;
      end
      S_LOAD: state_nxt = S_CALC;
      S_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = S_ATRW;
      end
      S_ATRW: begin
        if (sts.div_done) state_nxt = S_DEC;
      end
      S_DEC: begin
        cmd.decide = 1'b1;
        state_nxt  = S_PNLW;
      end
      S_PNLW: begin
        if (!sts.need_pnl || sts.div_done) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    cmd.atr_start = (state_r == S_CALC);
    cmd.pnl_start = (state_r == S_DEC);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

`default_nettype wire

### rtl/kbt_dp.sv
`default_nettype none
// kbt_dp: indicator state, close history ring, trade logic and shared divider
// depends on kbt_pkg, kbt_div

module kbt_dp
  import kbt_pkg::*;
#(
  parameter int HISTORY_DEPTH = HistDepthDef,
  parameter int ATR_SEED_BARS = AtrSeedDef
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire kbt_cfg_t          cfg,
  input  wire kbt_cmd_t          cmd,
  output kbt_sts_t               sts,
  input  wire logic [PriceW-1:0] bar_high,
  input  wire logic [PriceW-1:0] bar_low,
  input  wire logic [PriceW-1:0] bar_close,
  output logic [84:0]            res
);

  localparam int HW = $clog2(HISTORY_DEPTH);
  localparam int SW = $clog2(ATR_SEED_BARS + 1);

  logic [PriceW-1:0] mem [HISTORY_DEPTH];
  logic [PriceW-1:0] back_r;
  logic [HW-1:0]     pos_r;
  logic [PriceW-1:0] hi_r, lo_r, cl_r, prev_r;
  logic [AccW-1:0]   ema_r, atr_r;
  logic [CntW-1:0]   cnt_r;
  logic              hold_r, sval_r;
  logic [PriceW-1:0] entry_r, stop_r, eclose_r;
  logic [8:0]        lb_r;
  logic [1:0]        kind_r;
  logic              ent_r, need_r;
  logic [PnlW-1:0]   pnl_r;

  logic [HW-1:0]     lbh;
  logic [HW-1:0]     rd_addr;
  logic [8:0]        lbc;
  logic [PriceW:0]   d1, d2, d3, tr;
  logic [AccW+16:0]  ema_mix;
  logic [SW-1:0]     seed_i;
  logic [DivNumW-1:0] div_num, quo;
  logic [DivDenW-1:0] div_den;
  logic               div_neg, div_start, div_done;

  // lookback clamp to HISTORY_DEPTH-1
  always_comb begin
    if (32'(cfg.trend_lookback) > HISTORY_DEPTH - 1) lbc = 9'(HISTORY_DEPTH - 1);
    else                                             lbc = cfg.trend_lookback;
  end
  assign lbh     = HW'(lbc);
  assign rd_addr = (pos_r >= lbh) ? pos_r - lbh : HW'(HISTORY_DEPTH) - lbh + pos_r;

  // true range
  always_comb begin
    d1 = (hi_r >= lo_r) ? {1'b0, hi_r - lo_r} : '0;
    d2 = (hi_r >= prev_r) ? {1'b0, hi_r - prev_r} : {1'b0, prev_r - hi_r};
    d3 = (lo_r >= prev_r) ? {1'b0, lo_r - prev_r} : {1'b0, prev_r - lo_r};
    tr = d1;
    if (d2 > tr) tr = d2;
    if (d3 > tr) tr = d3;
  end

  assign ema_mix = ({17'b0, cfg.ema_coeff} * {cl_r, 12'b0}) / 1
                 + (57'(17'h10000 - {1'b0, cfg.ema_coeff}) * 57'(ema_r));
  assign seed_i  = (cnt_r <= CntW'(ATR_SEED_BARS)) ? SW'(cnt_r) : SW'(ATR_SEED_BARS);

  // trade decision terms
  logic [AccW+12:0] band;
  logic [PriceW:0]  esum;
  logic [PriceW-1:0] ep;
  logic signed [53:0] sraw;
  logic             warm, go_in, stop_hit, ema_hit;
  logic signed [PriceW+1:0] exit_px, pdiff;
  logic signed [63:0] pnum;
  logic [AccW-1:0]  atr_new;

  assign band     = 53'({ema_r, 8'b0}) + 53'(cfg.band_mult) * 53'(atr_r);
  assign esum     = {1'b0, cl_r} + (PriceW+1)'(cfg.half_spread);
  assign ep       = esum[PriceW] ? {PriceW{1'b1}} : esum[PriceW-1:0];
  assign sraw     = $signed({6'b0, ep, 20'b0})
                  - $signed({2'b0, 52'(cfg.stop_mult) * 52'(atr_r)});
  assign warm     = (32'(cnt_r) >= 32'(lbc) + 1);
  assign go_in    = (lbc != 0) && (cl_r > back_r) && ({cl_r, 20'b0} > band) && (atr_r != 0);
  assign stop_hit = sval_r && (lo_r <= stop_r);
  assign ema_hit  = ({cl_r, 12'b0} < ema_r);
  assign exit_px  = stop_hit ? $signed({2'b0, stop_r}) - $signed(30'(cfg.half_spread))
                             : $signed({2'b0, cl_r}) - $signed(30'(cfg.half_spread));
  assign pdiff    = exit_px - $signed({2'b0, entry_r});
  assign pnum     = 64'(pdiff) * 64'sd2560000
                  - 64'(cfg.half_spread) * 64'(cfg.fee_scale) * 64'sd20000;

  always_comb begin
    div_start = cmd.atr_start || (cmd.pnl_start && need_r);
    if (cmd.atr_start) begin
      div_num = 64'(atr_r) * 64'(seed_i - 1'b1) + {24'b0, tr[PriceW-1:0], 12'b0};
      div_den = DivDenW'(seed_i);
      div_neg = 1'b0;
    end else begin
      div_num = pnum[63] ? 64'(-pnum) : 64'(pnum);
      div_den = DivDenW'(eclose_r);
      div_neg = pnum[63];
    end
  end

  // need_r computed at decide so pnl_start sees it
  always_comb need_r = warm && hold_r && (stop_hit || ema_hit) && (cnt_r != 0);

  kbt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .neg   (div_neg),
    .quo   (quo),
    .done  (div_done)
  );

  assign sts     = {div_done, (kind_r != EXIT_NONE)};
  assign atr_new = quo[AccW-1:0];

  logic signed [63:0] qs;
  assign qs = $signed(quo);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hi_r   <= bar_high;
      lo_r   <= bar_low;
      cl_r   <= bar_close;
      back_r <= mem[rd_addr];
    end
    if (cmd.finish) mem[pos_r] <= cl_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ema_r <= '0; atr_r <= '0; prev_r <= '0; cnt_r <= '0; pos_r <= '0;
      hold_r <= 1'b0; sval_r <= 1'b0; entry_r <= '0; stop_r <= '0; eclose_r <= '0;
      kind_r <= EXIT_NONE; ent_r <= 1'b0; pnl_r <= '0; lb_r <= '0;
    end else begin
      if (cmd.load) begin
        cnt_r  <= (cnt_r == CntW'(CntMax)) ? cnt_r : cnt_r;
        kind_r <= EXIT_NONE;
        ent_r  <= 1'b0;
        pnl_r  <= '0;
      end
      if (cmd.calc) begin
        if (cnt_r == 0) ema_r <= {cl_r, 12'b0};
        else            ema_r <= ema_mix[AccW+15:16];
        prev_r <= cl_r;
      end
      if (div_done && !sts.need_pnl && cnt_r != 0 && !ent_r && lb_r == 0) begin
        atr_r <= atr_new;
        lb_r  <= 9'd1;
      end
      if (cmd.decide && warm) begin
        if (!hold_r) begin
          if (go_in) begin
            entry_r  <= ep;
            eclose_r <= cl_r;
            sval_r   <= !sraw[53];
            stop_r   <= sraw[53] ? '0 : sraw[47:20];
            hold_r   <= 1'b1;
            ent_r    <= 1'b1;
          end
        end else if (stop_hit) begin
          kind_r <= EXIT_STOP;
          hold_r <= 1'b0;
        end else if (ema_hit) begin
          kind_r <= EXIT_EMA;
          hold_r <= 1'b0;
        end
      end
      if (div_done && sts.need_pnl) begin
        if (eclose_r == 0) pnl_r <= pnum[63] ? 24'h800000 : ((pnum != 0) ? 24'h7FFFFF : '0);
        else if (qs > 64'sd8388607)  pnl_r <= 24'h7FFFFF;
        else if (qs < -64'sd8388608) pnl_r <= 24'h800000;
        else                         pnl_r <= qs[PnlW-1:0];
      end
      if (cmd.finish) begin
        pos_r <= (pos_r == HW'(HISTORY_DEPTH - 1)) ? '0 : pos_r + 1'b1;
        if (cnt_r != CntW'(CntMax)) cnt_r <= cnt_r + 1'b1;
        lb_r  <= '0;
      end
    end
  end

  // result: {ema 28, atr 28, in_pos, pnl 24, kind 2, closed, entered}
  assign res = {ema_r[AccW-1:12], atr_r[AccW-1:12], hold_r, pnl_r, kind_r,
                (kind_r != EXIT_NONE), ent_r};

endmodule

`default_nettype wire

### dv/tb_keltner_breakout_trend_trader.sv
`timescale 1ns / 1ps
// tb_keltner_breakout_trend_trader: self-checking bench for the keltner breakout trader
// drives price bars and apb register writes, predicts every result word and compares it
// depends on kbt_pkg and keltner_breakout_trend_trader

module tb_keltner_breakout_trend_trader
  import kbt_pkg::*;
();

  localparam logic [63:0] PX_MAX = 64'h0FFF_FFFF;
  localparam int HIST_N = 512;

  typedef struct packed {
    logic        entered;
    logic        closed;
    logic [1:0]  kind;
    logic [23:0] pnl;
    logic        in_pos;
    logic [27:0] atr;
    logic [27:0] ema;
  } bar_result_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [87:0] in_tdata;   // bar_high, bar_low, bar_close
  logic out_tvalid;
  logic out_tready;
  logic [87:0] out_tdata;  // entered, trade_closed, exit_kind, pnl_bps, in_position, atr_now, ema_now
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [4:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  keltner_breakout_trend_trader u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  logic [87:0] bar_q[$];
  bar_result_t expected_q[$];
  int errors;
  int bars_sent;
  int idle_mode;

  // shadow registers
  logic [15:0] m_coeff;
  logic [8:0]  m_lookback;
  logic [11:0] m_band;
  logic [11:0] m_stop;
  logic [15:0] m_half;
  logic [11:0] m_cost;

  // shadow trader state
  logic [27:0] m_hist[HIST_N];
  logic [8:0]  m_pos;
  logic [63:0] m_ema;
  logic [63:0] m_atr;
  logic [63:0] m_prev;
  logic [9:0]  m_count;
  logic        m_hold;
  logic        m_stop_ok;
  logic [63:0] m_entry;
  logic [63:0] m_stop_lvl;
  logic [63:0] m_entry_cl;

  longint walk_px;

  function automatic longint trade_bps(longint exit_px);
    longint num;
    longint q;
    num = (exit_px - longint'(m_entry)) * 64'sd2560000
        - 64'sd2 * longint'(m_half) * 64'sd10000 * longint'(m_cost);
    if (m_entry_cl == 0) q = num > 0 ? 8388607 : (num < 0 ? -8388608 : 0);
    else q = num / longint'(m_entry_cl);
    if (q > 8388607) q = 8388607;
    if (q < -8388608) q = -8388608;
    return q;
  endfunction

  task automatic add_bar(input logic [87:0] w);
    bar_q = {bar_q, w};
  endtask

  task automatic trade_bar(input logic [87:0] w);
    logic [63:0] hi, lo, cl, tr, t2, t3, lb, back, band, e;
    longint s, pnl;
    bar_result_t r;
    hi = 64'(w[27:0]);
    lo = 64'(w[55:28]);
    cl = 64'(w[83:56]);
    r = '0;
    pnl = 0;
    if (m_count == 0) begin
      m_ema = cl << 12;
    end else begin
      tr = hi >= lo ? hi - lo : 0;
      t2 = hi >= m_prev ? hi - m_prev : m_prev - hi;
      t3 = lo >= m_prev ? lo - m_prev : m_prev - lo;
      if (t2 > tr) tr = t2;
      if (t3 > tr) tr = t3;
      m_ema = (64'(m_coeff) * (cl << 12) + (64'd65536 - 64'(m_coeff)) * m_ema) >> 16;
      if (m_count <= 14) m_atr = (m_atr * 64'(m_count - 1) + (tr << 12)) / 64'(m_count);
      else m_atr = (m_atr * 64'd13 + (tr << 12)) / 64'd14;
    end
    m_prev = cl;
    lb = 64'(m_lookback);
    if (lb > HIST_N - 1) lb = HIST_N - 1;
    if (64'(m_count) >= lb + 1) begin
      if (!m_hold) begin
        back = lb == 0 ? cl : 64'(m_hist[9'(m_pos - 9'(lb))]);
        band = (m_ema << 8) + 64'(m_band) * m_atr;
        if (cl > back && (cl << 20) > band && m_atr > 0) begin
          e = cl + 64'(m_half);
          if (e > PX_MAX) e = PX_MAX;
          m_entry = e;
          m_entry_cl = cl;
          s = longint'(e << 20) - longint'(64'(m_stop) * m_atr);
          if (s < 0) begin
            m_stop_ok = 1'b0;
            m_stop_lvl = 0;
          end else begin
            m_stop_ok = 1'b1;
            m_stop_lvl = 64'(s) >> 20;
          end
          m_hold = 1'b1;
          r.entered = 1'b1;
        end
      end else begin
        if (m_stop_ok && lo <= m_stop_lvl) begin
          r.kind = EXIT_STOP;
          pnl = trade_bps(longint'(m_stop_lvl) - longint'(m_half));
        end else if ((cl << 12) < m_ema) begin
          r.kind = EXIT_EMA;
          pnl = trade_bps(longint'(cl) - longint'(m_half));
        end
        if (r.kind != EXIT_NONE) begin
          r.closed = 1'b1;
          m_hold = 1'b0;
        end
      end
    end
    m_hist[m_pos] = cl[27:0];
    m_pos = m_pos + 9'd1;
    if (m_count < 10'd1023) m_count = m_count + 10'd1;
    r.pnl = pnl[23:0];
    r.in_pos = m_hold;
    r.atr = m_atr[39:12];
    r.ema = m_ema[39:12];
    expected_q = {expected_q, r};
  endtask

  function automatic logic [87:0] pack_bar(logic [63:0] hi, logic [63:0] lo, logic [63:0] cl);
    return {4'd0, cl[27:0], lo[27:0], hi[27:0]};
  endfunction

  task automatic queue_walk(input int n, input int drift, input int noise);
    longint cl, hi, lo;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < 8) begin
        add_bar({4'd0, 28'($urandom), 28'($urandom), 28'($urandom)});
      end else begin
        walk_px = walk_px + drift + longint'($urandom_range(0, 2 * noise)) - noise;
        if ($urandom_range(0, 29) == 0) walk_px = walk_px - 6 * noise;
        if (walk_px < 0) walk_px = 0;
        if (walk_px > longint'(PX_MAX)) walk_px = PX_MAX;
        cl = walk_px;
        hi = cl + $urandom_range(0, noise);
        lo = cl - $urandom_range(0, noise);
        if (hi > longint'(PX_MAX)) hi = PX_MAX;
        if (lo < 0) lo = 0;
        add_bar(pack_bar(hi, lo, cl));
      end
    end
  endtask

  task automatic wait_quiet;
    while (bar_q.size() != 0 || in_tvalid || expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_EMA_COEFF: m_coeff = val[15:0];
      REG_LOOKBACK:  m_lookback = val[8:0];
      REG_BAND_MULT: m_band = val[11:0];
      REG_STOP_MULT: m_stop = val[11:0];
      REG_HALF_SPRD: m_half = val[15:0];
      REG_FEE_SCALE: m_cost = val[11:0];
      default: ;
    endcase
  endtask

  task automatic set_all(input int coeff, input int lb, input int band, input int stp,
                         input int half, input int cost);
    wait_quiet();
    reg_write(REG_EMA_COEFF, coeff);
    reg_write(REG_LOOKBACK, lb);
    reg_write(REG_BAND_MULT, band);
    reg_write(REG_STOP_MULT, stp);
    reg_write(REG_HALF_SPRD, half);
    reg_write(REG_FEE_SCALE, cost);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
    end else if (!in_tvalid || in_tready) begin
      if (bar_q.size() != 0 && !(idle_mode == 0 && $urandom_range(0, 99) < 36)
          && !(idle_mode == 1 && $urandom_range(0, 99) < 79)) begin
        in_tdata <= bar_q.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      case (idle_mode)
        0: out_tready <= $urandom_range(0, 99) >= 79;
        1: out_tready <= $urandom_range(0, 99) >= 36;
        default: out_tready <= 1'b1;
      endcase
    end
  end

  task automatic check_field(input string name, input logic [27:0] exp_v, input logic [27:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // monitor
  always @(posedge clk) begin
    bar_result_t got, exp_r;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        trade_bar(in_tdata);
        bars_sent++;
        if (bars_sent == 150) idle_mode = 1;
        if (bars_sent == 300) idle_mode = 2;
      end
      if (out_tvalid && out_tready) begin
        got = {out_tdata[0], out_tdata[1], out_tdata[3:2], out_tdata[27:4], out_tdata[28],
               out_tdata[56:29], out_tdata[84:57]};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %h", $time, out_tdata);
          errors++;
        end else begin
          exp_r = expected_q.pop_front();
          check_field("entered", 28'(exp_r.entered), 28'(got.entered));
          check_field("trade_closed", 28'(exp_r.closed), 28'(got.closed));
          check_field("exit_kind", 28'(exp_r.kind), 28'(got.kind));
          check_field("pnl_bps", 28'(exp_r.pnl), 28'(got.pnl));
          check_field("in_position", 28'(exp_r.in_pos), 28'(got.in_pos));
          check_field("atr_now", exp_r.atr, got.atr);
          check_field("ema_now", exp_r.ema, got.ema);
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("keltner_breakout_trend_trader verification failed");
    $finish;
  end

  initial begin
    errors = 0;
    bars_sent = 0;
    idle_mode = 0;
    rst_n = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    m_coeff = EMA_COEFF_RST;
    m_lookback = LOOKBACK_RST;
    m_band = BAND_MULT_RST;
    m_stop = STOP_MULT_RST;
    m_half = HALF_SPRD_RST;
    m_cost = FEE_SCALE_RST;
    m_pos = '0;
    m_ema = 0;
    m_atr = 0;
    m_prev = 0;
    m_count = '0;
    m_hold = 1'b0;
    m_stop_ok = 1'b0;
    m_entry = 0;
    m_stop_lvl = 0;
    m_entry_cl = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // field extremes, inverted bars, alternating bit patterns
    add_bar(pack_bar(0, 0, 0));
    add_bar(pack_bar(PX_MAX, PX_MAX, PX_MAX));
    add_bar(pack_bar(PX_MAX, 0, 64'h0800_0000));
    add_bar(pack_bar(0, PX_MAX, 5));
    add_bar(pack_bar(64'h0AAA_AAAA, 64'h0555_5555, 64'h0AAA_AAAA));
    add_bar(pack_bar(64'h0555_5555, 64'h0AAA_AAAA, 64'h0555_5555));
    add_bar(pack_bar(0, 0, PX_MAX));
    add_bar(pack_bar(PX_MAX, PX_MAX, 0));
    walk_px = 64'h0010_0000;
    queue_walk(12, 10, 40);

    // fast ema, short lookback, wide stop makes it invalid, max spread and cost
    set_all(65535, 3, 0, 4095, 65535, 4095);
    walk_px = 3000;
    queue_walk(60, 40, 300);
    walk_px = 64'h0FFF_F000;
    queue_walk(20, 300, 200);
    walk_px = 64'h0FFF_FFF0;
    queue_walk(10, 0, 16);

    // lookback of zero never enters, slowest ema
    set_all(1, 0, 4095, 0, 0, 0);
    walk_px = 64'h0002_0000;
    queue_walk(30, 30, 60);

    // typical settings, trending walk to open and close many trades
    set_all(13107, 5, 256, 640, 10, 256);
    walk_px = 64'h0004_0000;
    for (int seg = 0; seg < 6; seg++) queue_walk(25, (seg % 2) ? -30 : 60, 100);

    // longest lookback, ring fully wrapped
    set_all(6242, 511, 128, 256, 200, 512);
    walk_px = 64'h0008_0000;
    for (int seg = 0; seg < 6; seg++) queue_walk(25, (seg % 2) ? -40 : 50, 120);

    wait_quiet();
    if (errors == 0) begin
      $display("keltner_breakout_trend_trader verification clean");
    end else begin
      $display("keltner_breakout_trend_trader verification failed");
    end
    $finish;
  end

endmodule
